@@ rtl/scpa_pkg.sv @@
// Shared types and codes for the size class pool allocator.
// Request and result payloads, controller states, mode/owner/status codes.
`timescale 1ns / 1ps
`default_nettype none

package scpa_pkg;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] request_bytes;
        logic [15:0] block_address;
        logic [1:0]  owner;
        logic        pool_enabled;
    } scpa_req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [15:0] address;
        logic [3:0]  class_index;
    } scpa_rsp_t;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } scpa_state_t;

    localparam logic [1:0] MODE_ALLOC = 2'd0;
    localparam logic [1:0] MODE_FREE  = 2'd1;
    localparam logic [1:0] MODE_RESET = 2'd2;

    localparam logic [1:0] OWNER_SYSTEM = 2'd0;
    localparam logic [1:0] OWNER_POOL   = 2'd1;

    localparam logic [2:0] STAT_POP       = 3'd0;
    localparam logic [2:0] STAT_BUMP      = 3'd1;
    localparam logic [2:0] STAT_SYSTEM    = 3'd2;
    localparam logic [2:0] STAT_EXHAUSTED = 3'd3;
    localparam logic [2:0] STAT_FREED     = 3'd4;
    localparam logic [2:0] STAT_SYS_FREE  = 3'd5;
    localparam logic [2:0] STAT_FOREIGN   = 3'd6;
    localparam logic [2:0] STAT_RESET     = 3'd7;

    localparam logic [16:0] LIMIT_RESET = 17'd65536;

endpackage

`default_nettype wire

@@ rtl/size_class_pool_allocator.sv @@
// Size class pool allocator: top level with link and tag memories.
// Depends on scpa_pkg for payload structs, state enum and codes.
//
//  channel   | handshake           | payload
//  ----------+---------------------+-----------------------------------
//  request   | start / busy        | request (scpa_req_t)
//  result    | done (1-cycle pulse)| result  (scpa_rsp_t)
//  config    | cfg_valid/cfg_ready | cfg_data (pool_limit, 17 bits)
//
// Each request has an accept cycle and an execute cycle: the accept cycle issues
// the synchronous reads of the next-link and class-tag memories, the execute
// cycle uses the read data, writes the memories and head registers back.
// The result shows on the cycle after execute, overlapping the next accept.
// Reset empties the class lists and rewinds the bump cursor; memories are
// not cleared, so freeing a block never bump-allocated reads an unwritten tag.
// The receiver cannot stall; config is always ready.
`timescale 1ns / 1ps
`default_nettype none

module size_class_pool_allocator #(
    parameter int POOL_UNITS  = 65536,
    parameter int NUM_CLASSES = 9
) (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire scpa_pkg::scpa_req_t request,
    output logic                 done,
    output scpa_pkg::scpa_rsp_t  result,
    input  wire                  cfg_valid,
    output logic                 cfg_ready,
    input  wire  [16:0]          cfg_data
);

    // Addresses are 16 bits wide, so the memories never hold more than 64K.
    localparam int MEM_DEPTH = (POOL_UNITS < 65536) ? POOL_UNITS : 65536;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam int CW        = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam logic [16:0] DEPTH_L    = 17'(MEM_DEPTH);
    localparam logic [3:0]  LAST_CLASS = 4'(NUM_CLASSES - 1);
    localparam logic [4:0]  NUM_CLS_L  = 5'(NUM_CLASSES);

    // ---------------------------------------------------------------
    // State
    // ---------------------------------------------------------------
    scpa_pkg::scpa_state_t state_reg, state_next;
    scpa_pkg::scpa_req_t   req_reg;
    logic [CW-1:0]         cls_reg;     // smallest fitting class
    logic                  fit_reg;     // some class fits request_bytes
    logic [16:0]           limit_reg;
    logic [16:0]           cursor_reg, cursor_next;
    logic                  head_valid_reg [NUM_CLASSES];
    logic [15:0]           head_addr_reg  [NUM_CLASSES];
    scpa_pkg::scpa_rsp_t   rsp_reg, rsp_next;
    logic                  done_reg, done_next;

    // Memories: next link (valid + address) and class tag per unit.
    logic [16:0] link_mem [MEM_DEPTH];
    logic [3:0]  tag_mem  [MEM_DEPTH];
    logic [16:0] link_rd;
    logic [3:0]  tag_rd;
    logic [AW-1:0] link_raddr, link_waddr, tag_waddr;
    logic [16:0]   link_wdata;
    logic          link_we, tag_we;
    logic [3:0]    tag_wdata;

    // Head register update
    logic          head_we, heads_clear, head_wvalid;
    logic [CW-1:0] head_wsel;
    logic [15:0]   head_waddr;

    logic accept;
    logic [CW-1:0] pick_cls;
    logic          pick_fit;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;
    assign done      = done_reg;
    assign result    = rsp_reg;

    // ---------------------------------------------------------------
    // Class selection at accept: independent compares, smallest wins.
    // ---------------------------------------------------------------
    always_comb
    begin
        pick_cls = '0;
        pick_fit = 1'b0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--)
        begin
            if (request.request_bytes <= (32'd16 << c))
            begin
                pick_cls = CW'(c);
                pick_fit = 1'b1;
            end
        end
    end

    // Read address: head of the chosen class, for a possible pop.
    assign link_raddr = head_addr_reg[pick_cls][AW-1:0];

    // ---------------------------------------------------------------
    // Memories, synchronous read
    // ---------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (link_we)
        begin
            link_mem[link_waddr] <= link_wdata;
        end
        link_rd <= link_mem[link_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (tag_we)
        begin
            tag_mem[tag_waddr] <= tag_wdata;
        end
        tag_rd <= tag_mem[request.block_address[AW-1:0]];
    end

    // ---------------------------------------------------------------
    // FSM: next state
    // ---------------------------------------------------------------
    always_comb
    begin
        case (state_reg)
            scpa_pkg::ST_IDLE: state_next = accept ? scpa_pkg::ST_EXEC : scpa_pkg::ST_IDLE;
            scpa_pkg::ST_EXEC: state_next = scpa_pkg::ST_IDLE;
            default:           state_next = scpa_pkg::ST_IDLE;
        endcase
    end

    // FSM: outputs
    always_comb
    begin
        case (state_reg)
            scpa_pkg::ST_IDLE: busy = 1'b0;
            scpa_pkg::ST_EXEC: busy = 1'b1;
            default:           busy = 1'b1;
        endcase
    end

    // ---------------------------------------------------------------
    // Execute: read-modify-write of heads, links, tags and cursor
    // ---------------------------------------------------------------
    logic [3:0]    tag_clamped;
    logic [CW-1:0] free_cls;
    logic [17:0]   bump_end;
    logic [17:0]   units;
    logic [16:0]   eff_limit;
    logic          free_in_range;
    logic          head_in_range;
    logic [15:0]   pop_head;

    always_comb
    begin
        tag_clamped   = ({1'b0, tag_rd} >= NUM_CLS_L) ? LAST_CLASS : tag_rd;
        free_cls      = tag_clamped[CW-1:0];
        units         = 18'd1 + (18'd1 << cls_reg);
        bump_end      = {1'b0, cursor_reg} + units;
        eff_limit     = (limit_reg < DEPTH_L) ? limit_reg : DEPTH_L;
        free_in_range = {1'b0, req_reg.block_address} < DEPTH_L;
        pop_head      = head_addr_reg[cls_reg];
        head_in_range = {1'b0, pop_head} < DEPTH_L;
    end

    always_comb
    begin
        rsp_next    = '0;
        done_next   = 1'b0;
        cursor_next = cursor_reg;
        link_we     = 1'b0;
        link_waddr  = req_reg.block_address[AW-1:0];
        link_wdata  = {head_valid_reg[free_cls], head_addr_reg[free_cls]};
        tag_we      = 1'b0;
        tag_waddr   = cursor_reg[AW-1:0];
        tag_wdata   = 4'(cls_reg);
        head_we     = 1'b0;
        heads_clear = 1'b0;
        head_wsel   = cls_reg;
        head_wvalid = 1'b0;
        head_waddr  = '0;

        if (state_reg == scpa_pkg::ST_EXEC)
        begin
            case (req_reg.mode)
                scpa_pkg::MODE_ALLOC:
                begin
                    done_next = 1'b1;
                    if (!fit_reg || !req_reg.pool_enabled)
                    begin
                        rsp_next.status = scpa_pkg::STAT_SYSTEM;
                    end
                    else if (head_valid_reg[cls_reg])
                    begin
                        // pop: new head is the stored link of the old head
                        rsp_next.status      = scpa_pkg::STAT_POP;
                        rsp_next.address     = pop_head;
                        rsp_next.class_index = 4'(cls_reg);
                        head_we     = 1'b1;
                        head_wvalid = head_in_range ? link_rd[16] : 1'b0;
                        head_waddr  = head_in_range ? link_rd[15:0] : 16'd0;
                    end
                    else
                    begin
                        rsp_next.class_index = 4'(cls_reg);
                        if (bump_end <= {1'b0, eff_limit})
                        begin
                            rsp_next.status  = scpa_pkg::STAT_BUMP;
                            rsp_next.address = cursor_reg[15:0];
                            tag_we      = {1'b0, cursor_reg[15:0]} < DEPTH_L;
                            cursor_next = bump_end[16:0];
                        end
                        else
                        begin
                            rsp_next.status = scpa_pkg::STAT_EXHAUSTED;
                        end
                    end
                end
                scpa_pkg::MODE_FREE:
                begin
                    done_next        = 1'b1;
                    rsp_next.address = req_reg.block_address;
                    if (req_reg.owner == scpa_pkg::OWNER_SYSTEM)
                    begin
                        rsp_next.status = scpa_pkg::STAT_SYS_FREE;
                    end
                    else if (req_reg.owner != scpa_pkg::OWNER_POOL || !free_in_range)
                    begin
                        rsp_next.status = scpa_pkg::STAT_FOREIGN;
                    end
                    else
                    begin
                        // push: link to old head, block becomes head
                        rsp_next.status      = scpa_pkg::STAT_FREED;
                        rsp_next.class_index = tag_clamped;
                        link_we     = 1'b1;
                        head_we     = 1'b1;
                        head_wsel   = free_cls;
                        head_wvalid = 1'b1;
                        head_waddr  = req_reg.block_address;
                    end
                end
                scpa_pkg::MODE_RESET:
                begin
                    done_next       = 1'b1;
                    rsp_next.status = scpa_pkg::STAT_RESET;
                    heads_clear     = 1'b1;
                    cursor_next     = '0;
                end
                default:
                begin
                    done_next = 1'b0;
                end
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= scpa_pkg::ST_IDLE;
            limit_reg  <= scpa_pkg::LIMIT_RESET;
            cursor_reg <= '0;
            done_reg   <= 1'b0;
            for (int i = 0; i < NUM_CLASSES; i++)
            begin
                head_valid_reg[i] <= 1'b0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            cursor_reg <= cursor_next;
            done_reg   <= done_next;
            if (cfg_valid && cfg_ready)
            begin
                limit_reg <= cfg_data;
            end
            if (heads_clear)
            begin
                for (int i = 0; i < NUM_CLASSES; i++)
                begin
                    head_valid_reg[i] <= 1'b0;
                end
            end
            else if (head_we)
            begin
                head_valid_reg[head_wsel] <= head_wvalid;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
        if (accept)
        begin
            req_reg <= request;
            cls_reg <= pick_cls;
            fit_reg <= pick_fit;
        end
        if (head_we && !heads_clear)
        begin
            head_addr_reg[head_wsel] <= head_waddr;
        end
    end

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> state_reg == scpa_pkg::ST_EXEC)
        else $error("accepted request did not enter execute");

    a_exec_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == scpa_pkg::ST_EXEC |=> state_reg == scpa_pkg::ST_IDLE)
        else $error("execute lasted more than one cycle");

    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == scpa_pkg::ST_EXEC))
        else $error("result strobe without a preceding execute");

    a_write_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (link_we || tag_we || head_we) |-> state_reg == scpa_pkg::ST_EXEC)
        else $error("memory or head write outside execute");

    a_cursor_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= DEPTH_L)
        else $error("bump cursor beyond pool");

endmodule

`default_nettype wire
